// ===== rtl/dfe_pkg.sv =====
// Package for the frame duty encoder: shared constants, register indexes
// and the frame item carried from the front end to the serializer.
// No dependencies.
`default_nettype none

package dfe_pkg;

   localparam int CMD_WIDTH     = 10;
   localparam int CHAN_WIDTH    = 2;
   localparam int DUTY_WIDTH    = 8;
   localparam int VALUE_WIDTH   = 11;
   localparam int FRAME_BITS    = 16;
   localparam int SLOT_WIDTH    = 5;
   localparam int CSR_IDX_WIDTH = 1;

   localparam logic [CMD_WIDTH-1:0]   CMD_MAX    = 10'd1000;
   localparam logic [CMD_WIDTH-1:0]   CMD_SPAN   = 10'd999;
   localparam logic [VALUE_WIDTH-1:0] VALUE_BASE = 11'd48;

   // gap slot index follows the 16 bit slots
   localparam logic [SLOT_WIDTH-1:0] GAP_SLOT = 5'(FRAME_BITS);

   localparam logic [DUTY_WIDTH-1:0] ONE_DUTY_RESET  = 8'd180;
   localparam logic [DUTY_WIDTH-1:0] ZERO_DUTY_RESET = 8'd90;
   localparam logic [DUTY_WIDTH-1:0] GAP_DUTY        = 8'd0;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ONE_BIT_DUTY  = 1'b0,
      CSR_ZERO_BIT_DUTY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic [CHAN_WIDTH-1:0] channel;
   } frame_item_type;

endpackage

`default_nettype wire

// ===== rtl/dfe_req_if.sv =====
// Command channel: valid/ready handshake with throttle and channel payload.
// Depends on dfe_pkg for field widths.
`default_nettype none

interface dfe_req_if;
   logic                          valid;
   logic                          ready;
   logic [dfe_pkg::CMD_WIDTH-1:0]  throttle_command;
   logic [dfe_pkg::CHAN_WIDTH-1:0] motor_channel;

   modport source (output valid, output throttle_command, output motor_channel, input ready);
   modport sink   (input valid, input throttle_command, input motor_channel, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfe_rsp_if.sv =====
// Duty word channel: valid/ready handshake with duty, channel and last flag.
// Depends on dfe_pkg for field widths.
`default_nettype none

interface dfe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dfe_pkg::DUTY_WIDTH-1:0] duty_word;
   logic [dfe_pkg::CHAN_WIDTH-1:0] out_channel;
   logic                          last_word;

   modport source (output valid, output duty_word, output out_channel, output last_word,
                   input ready);
   modport sink   (input valid, input duty_word, input out_channel, input last_word,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/dfe_front.sv =====
// Front end: accepts commands, saturates and scales the throttle, builds the
// 16-bit frame with checksum and holds it in one stage register.
// Depends on dfe_pkg and dfe_req_if.
`default_nettype none

module dfe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   dfe_req_if.sink              req_bus,
   output logic                 push_valid,
   output dfe_pkg::frame_item_type push_item,
   input  wire logic            push_ready
);
   import dfe_pkg::*;

   logic                   stage_valid_ff, stage_valid_in;
   frame_item_type         stage_item_ff, stage_item_in;
   logic [CMD_WIDTH-1:0]   cmd_sat;
   logic [CMD_WIDTH-1:0]   cmd_less;
   logic [VALUE_WIDTH-1:0] value;
   logic [11:0]            packet;
   logic [3:0]             checksum;
   logic                   accept;

   assign req_bus.ready = !stage_valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_valid    = stage_valid_ff;
   assign push_item     = stage_item_ff;

   always_comb begin
      cmd_sat  = (req_bus.throttle_command > CMD_MAX) ? CMD_MAX : req_bus.throttle_command;
      cmd_less = cmd_sat - 10'd1;
      // (c-1)*1999/999 with c-1 <= 999 is 2*(c-1), plus one only at c-1 == 999
      if (cmd_sat == '0) begin
         value = '0;
      end else begin
         value = VALUE_BASE + {cmd_less, 1'b0} + VALUE_WIDTH'(cmd_less == CMD_SPAN);
      end
      packet   = {value, 1'b0};
      checksum = ~(packet[3:0] ^ packet[7:4] ^ packet[11:8]);

      stage_item_in  = stage_item_ff;
      stage_valid_in = stage_valid_ff;
      if (push_ready) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in        = 1'b1;
         stage_item_in.frame   = {packet, checksum};
         stage_item_in.channel = req_bus.motor_channel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

endmodule

`default_nettype wire

// ===== rtl/dfe_fifo.sv =====
// Small frame queue between front end and serializer.
// Depends on dfe_pkg for the frame item type.
`default_nettype none

module dfe_fifo #(
   parameter int DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dfe_pkg::frame_item_type push_item,
   output logic                    push_ready,
   input  wire logic               pop,
   output dfe_pkg::frame_item_type pop_item,
   output logic                    pop_valid
);
   import dfe_pkg::*;

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT  = CNT_WIDTH'(DEPTH);

   frame_item_type         entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("frame queue count over depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("serializer popped an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/dfe_back.sv =====
// Serializer: pops frames from the queue and emits 16 bit-slot duty words
// plus a trailing gap word through an output register.
// Depends on dfe_pkg and dfe_rsp_if.
`default_nettype none

module dfe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire dfe_pkg::frame_item_type q_item,
   output logic                    q_pop,
   input  wire logic [dfe_pkg::DUTY_WIDTH-1:0] one_duty,
   input  wire logic [dfe_pkg::DUTY_WIDTH-1:0] zero_duty,
   dfe_rsp_if.source               rsp_bus
);
   import dfe_pkg::*;

   logic                  active_ff, active_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic [CHAN_WIDTH-1:0] chan_ff, chan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_WIDTH-1:0] rsp_duty_ff, rsp_duty_in;
   logic [CHAN_WIDTH-1:0] rsp_chan_ff, rsp_chan_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  advance;

   assign advance             = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.duty_word   = rsp_duty_ff;
   assign rsp_bus.out_channel = rsp_chan_ff;
   assign rsp_bus.last_word   = rsp_last_ff;

   always_comb begin
      active_in    = active_ff;
      shift_in     = shift_ff;
      slot_in      = slot_ff;
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;

      if (advance) begin
         rsp_valid_in = 1'b0;
      end

      if (!active_ff) begin
         if (q_valid) begin
            q_pop     = 1'b1;
            active_in = 1'b1;
            shift_in  = q_item.frame;
            chan_in   = q_item.channel;
            slot_in   = '0;
         end
      end else if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_chan_in  = chan_ff;
         if (slot_ff == GAP_SLOT) begin
            rsp_duty_in = GAP_DUTY;
            rsp_last_in = 1'b1;
            // load the next frame behind the gap word so frames run back to back
            if (q_valid) begin
               q_pop    = 1'b1;
               shift_in = q_item.frame;
               chan_in  = q_item.channel;
               slot_in  = '0;
            end else begin
               active_in = 1'b0;
            end
         end else begin
            rsp_duty_in = shift_ff[FRAME_BITS-1] ? one_duty : zero_duty;
            rsp_last_in = 1'b0;
            shift_in    = {shift_ff[FRAME_BITS-2:0], 1'b0};
            slot_in     = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff    <= shift_in;
      chan_ff     <= chan_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= GAP_SLOT)
      else $error("slot counter past gap slot");

   a_idle_after_gap: assert property (@(posedge clock) disable iff (reset)
      (active_ff && advance && slot_ff == GAP_SLOT && !q_valid) |=> !active_ff)
      else $error("serializer still busy after gap word with empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/dshot_frame_duty_encoder.sv =====
// DShot frame duty encoder, top level.
// req_bus (sink): one beat per throttle command with a motor channel. Commands
//    above 1000 saturate; the command is scaled to an 11-bit value, a zero
//    telemetry bit and a 4-bit checksum complete a 16-bit frame.
// rsp_bus (source): 17 beats per command: 16 bit-slot duty words, MSB first,
//    using the one/zero duty registers, then a gap word of 0 with last_word set.
// csr_*: plain write port; index 0 is the one-bit duty, index 1 the zero-bit
//    duty. Writes land at the clock edge where csr_write_enable is high.
// The first duty word passes the front-end stage register, the frame queue and
//    the serializer into the output register. The serializer emits one word per
//    cycle unless stalled; a new frame is loaded behind each gap word.
// The front end and a QUEUE_DEPTH frame queue keep accepting commands while the
//    serializer works, so up to QUEUE_DEPTH + 3 commands can be in flight,
//    counting one whose gap word still waits in the output register.
// Reset clears all control state and sets the duty registers to 180 and 90.
// When the receiver stalls, the output word holds; the serializer, then the
//    queue and the front end fill and req_bus.ready drops.
`default_nettype none

module dshot_frame_duty_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   dfe_req_if.sink   req_bus,
   dfe_rsp_if.source rsp_bus,
   input  wire logic csr_write_enable,
   input  wire logic [dfe_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [dfe_pkg::DUTY_WIDTH-1:0]    csr_write_data
);
   import dfe_pkg::*;

   logic [DUTY_WIDTH-1:0] one_duty_ff, one_duty_in;
   logic [DUTY_WIDTH-1:0] zero_duty_ff, zero_duty_in;
   logic                  push_valid;
   logic                  push_ready;
   frame_item_type        push_item;
   logic                  q_valid;
   logic                  q_pop;
   frame_item_type        q_item;

   always_comb begin
      one_duty_in  = one_duty_ff;
      zero_duty_in = zero_duty_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ONE_BIT_DUTY:  one_duty_in  = csr_write_data;
            CSR_ZERO_BIT_DUTY: zero_duty_in = csr_write_data;
            default: begin
               one_duty_in  = one_duty_ff;
               zero_duty_in = zero_duty_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_duty_ff  <= ONE_DUTY_RESET;
         zero_duty_ff <= ZERO_DUTY_RESET;
      end else begin
         one_duty_ff  <= one_duty_in;
         zero_duty_ff <= zero_duty_in;
      end
   end

   dfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   dfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (q_pop),
      .pop_item   (q_item),
      .pop_valid  (q_valid)
   );

   dfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .one_duty  (one_duty_ff),
      .zero_duty (zero_duty_ff),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
